### rtl/core/kwm_pkg.sv
// Package for the k-way run merger.
// Holds the fixed field widths, the register reset value and the result flag struct.
// No dependencies.
`timescale 1ns / 1ps

package kwm_pkg;

	localparam int SRC_BITS = 3;
	localparam int CFG_BITS = 4;
	localparam int CNT_BITS = 4;

	localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd2;

	// Status fields of one result, apart from key and payload.
	typedef struct packed {
		logic                run_end;
		logic                protocol_error;
		logic [SRC_BITS-1:0] src;
	} kwm_flags_t;

endpackage

### rtl/core/k_way_run_merger.sv
// Top level of the k-way run merger: configuration register, result register, sequencer.
// Uses kwm_pkg and kwm_seq.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------------
//  request  | src_valid/src_ready  | source, sort_key, payload, end_marker
//  result   | res_valid/res_ready  | out_key, out_payload, refill_source, run_end,
//           |                      | protocol_error
//  config   | cfg_wen              | cfg_wdata (active_sources)
//
// A request that emits a record is taken in the idle step, then runs the minimum scan over
// the head memory read port, the shift of the list and the emit step. A wrong source goes
// straight to emit, a run end through the scan step; a priming request that is not the last
// keeps the sequencer idle. Reset clears all control state; the head memory needs no clearing.
// A request is taken while an earlier result still waits in the result register; the sequencer
// stalls in its emit step until that register is free.
`timescale 1ns / 1ps

module k_way_run_merger #(
	parameter int MAX_SOURCES  = 8,
	parameter int KEY_BITS     = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [kwm_pkg::CFG_BITS-1:0]  cfg_wdata,
	input  logic                          src_valid,
	output logic                          src_ready,
	input  logic [kwm_pkg::SRC_BITS-1:0]  source,
	input  logic [KEY_BITS-1:0]           sort_key,
	input  logic [PAYLOAD_BITS-1:0]       payload,
	input  logic                          end_marker,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [KEY_BITS-1:0]           out_key,
	output logic [PAYLOAD_BITS-1:0]       out_payload,
	output logic [kwm_pkg::SRC_BITS-1:0]  refill_source,
	output logic                          run_end,
	output logic                          protocol_error
);

	logic [kwm_pkg::CFG_BITS-1:0] active_q;
	logic                         res_valid_q;
	logic [KEY_BITS-1:0]          out_key_q;
	logic [PAYLOAD_BITS-1:0]      out_pay_q;
	kwm_pkg::kwm_flags_t          out_flags_q;

	logic                         res_free;
	logic                         res_push;
	logic [KEY_BITS-1:0]          seq_key;
	logic [PAYLOAD_BITS-1:0]      seq_pay;
	kwm_pkg::kwm_flags_t          seq_flags;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= kwm_pkg::CFG_RESET;
		end else if (cfg_wen) begin
			active_q <= cfg_wdata;
		end
	end

	kwm_seq #(
		.MAX_SOURCES  (MAX_SOURCES),
		.KEY_BITS     (KEY_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.active_sources (active_q),
		.src_valid      (src_valid),
		.src_ready      (src_ready),
		.source         (source),
		.sort_key       (sort_key),
		.payload        (payload),
		.end_marker     (end_marker),
		.res_free       (res_free),
		.res_push       (res_push),
		.res_key        (seq_key),
		.res_payload    (seq_pay),
		.res_flags      (seq_flags)
	);

	assign res_free = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_push) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_key_q   <= seq_key;
			out_pay_q   <= seq_pay;
			out_flags_q <= seq_flags;
		end
	end

	assign res_valid      = res_valid_q;
	assign out_key        = out_key_q;
	assign out_payload    = out_pay_q;
	assign refill_source  = out_flags_q.src;
	assign run_end        = out_flags_q.run_end;
	assign protocol_error = out_flags_q.protocol_error;

endmodule

### rtl/core/kwm_head_mem.sv
// Head list memory of the k-way run merger.
// One write port and one read port with registered read data; no dependencies.
`timescale 1ns / 1ps

module kwm_head_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3,
	parameter int DW    = 51
) (
	input  logic          clk,
	input  logic          wen,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/kwm_seq.sv
// Sequencer of the k-way run merger: request intake, priming, minimum scan and list shift.
// Uses kwm_pkg and the head list memory kwm_head_mem.
`timescale 1ns / 1ps

module kwm_seq #(
	parameter int MAX_SOURCES  = 8,
	parameter int KEY_BITS     = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [kwm_pkg::CFG_BITS-1:0]  active_sources,
	input  logic                          src_valid,
	output logic                          src_ready,
	input  logic [kwm_pkg::SRC_BITS-1:0]  source,
	input  logic [KEY_BITS-1:0]           sort_key,
	input  logic [PAYLOAD_BITS-1:0]       payload,
	input  logic                          end_marker,
	input  logic                          res_free,
	output logic                          res_push,
	output logic [KEY_BITS-1:0]           res_key,
	output logic [PAYLOAD_BITS-1:0]       res_payload,
	output kwm_pkg::kwm_flags_t           res_flags
);

	localparam int IW = $clog2(MAX_SOURCES);
	localparam int CW = $clog2(MAX_SOURCES + 1);
	localparam int SW = kwm_pkg::SRC_BITS;
	localparam int NW = kwm_pkg::CNT_BITS;
	localparam int EW = KEY_BITS + PAYLOAD_BITS + SW;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_SHIFT = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]              state_q;
	logic [CW-1:0]           head_count_q;
	logic                    priming_q;
	logic [NW-1:0]           primed_q;
	logic [SW-1:0]           awaited_q;
	logic [CW-1:0]           rd_cnt_q;
	logic                    rd_vld_s1;
	logic [IW-1:0]           rd_idx_s1;
	logic [KEY_BITS-1:0]     best_key_q;
	logic [PAYLOAD_BITS-1:0] best_pay_q;
	logic [SW-1:0]           best_src_q;
	logic [IW-1:0]           best_idx_q;
	logic [KEY_BITS-1:0]     res_key_q;
	logic [PAYLOAD_BITS-1:0] res_pay_q;
	kwm_pkg::kwm_flags_t     res_flags_q;

	logic [NW-1:0]           grp;
	logic [NW-1:0]           expected;
	logic [NW-1:0]           primed_inc;
	logic                    src_acc;
	logic                    src_ok;
	logic                    app;
	logic                    last_prime;
	logic                    issue;
	logic                    take;
	logic                    scan_done;
	logic                    shift_done;
	logic [IW-1:0]           best_next;
	logic                    mem_wen;
	logic [IW-1:0]           mem_waddr;
	logic [EW-1:0]           mem_wdata;
	logic [EW-1:0]           mem_rdata;
	logic [KEY_BITS-1:0]     rd_key;
	logic [PAYLOAD_BITS-1:0] rd_pay;
	logic [SW-1:0]           rd_src;

	// Effective group size: zero acts as one, large values are clamped.
	always_comb begin
		if (active_sources == '0) begin
			grp = NW'(1);
		end else if (int'(active_sources) > MAX_SOURCES) begin
			grp = NW'(MAX_SOURCES);
		end else begin
			grp = active_sources;
		end
	end

	assign src_ready  = (state_q == ST_IDLE);
	assign src_acc    = src_valid && src_ready;
	assign expected   = priming_q ? primed_q : NW'(awaited_q);
	assign src_ok     = (NW'(source) == expected);
	assign app        = src_acc && src_ok && !end_marker && (head_count_q < CW'(MAX_SOURCES));
	assign primed_inc = primed_q + NW'(1);
	assign last_prime = (primed_inc >= grp);

	assign issue  = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (rd_cnt_q < head_count_q);
	assign rd_key = mem_rdata[EW-1 -: KEY_BITS];
	assign rd_pay = mem_rdata[SW +: PAYLOAD_BITS];
	assign rd_src = mem_rdata[SW-1:0];

	// A strictly smaller key replaces the best, so the earliest entry wins ties.
	assign take      = (state_q == ST_SCAN) && rd_vld_s1
		&& ((rd_idx_s1 == '0) || (rd_key < best_key_q));
	assign scan_done = (state_q == ST_SCAN) && rd_vld_s1
		&& ((CW'(rd_idx_s1) + CW'(1)) == head_count_q);
	assign best_next = take ? rd_idx_s1 : best_idx_q;
	assign shift_done = (state_q == ST_SHIFT) && !issue && !rd_vld_s1;

	// During the shift each entry read is written one place lower when its read data returns.
	// Writes therefore stay below the read pointer and never meet a pending read.
	always_comb begin
		if (state_q == ST_SHIFT) begin
			mem_wen   = rd_vld_s1;
			mem_waddr = rd_idx_s1 - IW'(1);
			mem_wdata = mem_rdata;
		end else begin
			mem_wen   = app;
			mem_waddr = head_count_q[IW-1:0];
			mem_wdata = {sort_key, payload, source};
		end
	end

	kwm_head_mem #(
		.DEPTH (MAX_SOURCES),
		.AW    (IW),
		.DW    (EW)
	) u_mem (
		.clk   (clk),
		.wen   (mem_wen),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_cnt_q[IW-1:0]),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_count_q <= '0;
			priming_q    <= 1'b1;
			primed_q     <= '0;
			awaited_q    <= '0;
			rd_cnt_q     <= '0;
			rd_vld_s1    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					rd_cnt_q  <= '0;
					rd_vld_s1 <= 1'b0;
					if (app) begin
						head_count_q <= head_count_q + CW'(1);
					end
					if (src_acc) begin
						if (!src_ok) begin
							state_q <= ST_EMIT;
						end else if (priming_q) begin
							primed_q  <= primed_inc;
							awaited_q <= primed_inc[SW-1:0];
							if (last_prime) begin
								priming_q <= 1'b0;
								state_q   <= ST_SCAN;
							end
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (head_count_q == '0) begin
						priming_q <= 1'b1;
						primed_q  <= '0;
						awaited_q <= '0;
						state_q   <= ST_EMIT;
					end else if (scan_done) begin
						rd_cnt_q  <= CW'(best_next) + CW'(1);
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_SHIFT;
					end else begin
						rd_vld_s1 <= issue;
						if (issue) begin
							rd_cnt_q <= rd_cnt_q + CW'(1);
						end
					end
				end
				ST_SHIFT: begin
					rd_vld_s1 <= issue;
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (shift_done) begin
						head_count_q <= head_count_q - CW'(1);
						awaited_q    <= best_src_q;
						state_q      <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_cnt_q[IW-1:0];
		if (take) begin
			best_key_q <= rd_key;
			best_pay_q <= rd_pay;
			best_src_q <= rd_src;
			best_idx_q <= rd_idx_s1;
		end
		if (src_acc && !src_ok) begin
			res_key_q   <= '0;
			res_pay_q   <= '0;
			res_flags_q <= '{run_end: 1'b0, protocol_error: 1'b1, src: '0};
		end else if ((state_q == ST_SCAN) && (head_count_q == '0)) begin
			res_key_q   <= '0;
			res_pay_q   <= '0;
			res_flags_q <= '{run_end: 1'b1, protocol_error: 1'b0, src: '0};
		end else if (shift_done) begin
			res_key_q   <= best_key_q;
			res_pay_q   <= best_pay_q;
			res_flags_q <= '{run_end: 1'b0, protocol_error: 1'b0, src: best_src_q};
		end
	end

	assign res_push    = (state_q == ST_EMIT) && res_free;
	assign res_key     = res_key_q;
	assign res_payload = res_pay_q;
	assign res_flags   = res_flags_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_count_q <= CW'(MAX_SOURCES))
		else $error("head list count above capacity");

	a_wrong_src_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(src_acc && !src_ok) |=> (state_q == ST_EMIT) && res_flags_q.protocol_error)
		else $error("wrong source did not raise an error result");

	a_shift_write_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SHIFT) && mem_wen) |-> (CW'(mem_waddr) < head_count_q))
		else $error("shift writes beyond the head list");

	a_no_priming_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> !priming_q && (head_count_q != '0))
		else $error("shift while priming or with an empty list");

	a_count_drops_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		shift_done |=> (head_count_q == $past(head_count_q) - CW'(1)))
		else $error("head list count not reduced after an emission");
`endif

endmodule

### bench/kwm_checker.sv
// Checker for the k-way run merger: watches the request, result and register ports,
// keeps its own model of the head list and compares every result with the oldest prediction.
// Depends on kwm_pkg for the register width, its reset value and the result flag struct.
`timescale 1ns / 1ps

module kwm_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [kwm_pkg::CFG_BITS-1:0] cfg_wdata,
	input  logic                         src_valid,
	input  logic                         src_ready,
	input  logic [kwm_pkg::SRC_BITS-1:0] source,
	input  logic [15:0]                  sort_key,
	input  logic [31:0]                  payload,
	input  logic                         end_marker,
	input  logic                         res_valid,
	input  logic                         res_ready,
	input  logic [15:0]                  out_key,
	input  logic [31:0]                  out_payload,
	input  logic [kwm_pkg::SRC_BITS-1:0] refill_source,
	input  logic                         run_end,
	input  logic                         protocol_error,
	output int                           mismatches,
	output int                           pending
);

	localparam int MAX_HEADS = 8;

	typedef struct packed {
		logic [15:0]         key;
		logic [31:0]         pay;
		kwm_pkg::kwm_flags_t flags;
	} merge_out_t;

	logic [15:0]                  head_key [MAX_HEADS];
	logic [31:0]                  head_pay [MAX_HEADS];
	logic [kwm_pkg::SRC_BITS-1:0] head_src [MAX_HEADS];
	int unsigned                  n_heads;
	bit                           priming;
	logic [kwm_pkg::CNT_BITS-1:0] primed;
	logic [kwm_pkg::SRC_BITS-1:0] awaited;
	logic [kwm_pkg::CFG_BITS-1:0] group_reg;

	merge_out_t emitted_q[$];
	merge_out_t got_r;
	merge_out_t want_r;
	merge_out_t new_r;

	function automatic int unsigned group_width();
		if (group_reg == 0)
			return 1;
		if (group_reg > MAX_HEADS)
			return MAX_HEADS;
		return 32'(group_reg);
	endfunction

	// Takes the smallest head out of the list; an empty list closes the merge group.
	function automatic void take_smallest(output merge_out_t r);
		int unsigned best;
		r = '0;
		if (n_heads == 0) begin
			priming = 1'b1;
			primed = '0;
			awaited = '0;
			r.flags.run_end = 1'b1;
			return;
		end
		best = 0;
		for (int unsigned i = 1; i < n_heads; i++)
			if (head_key[i] < head_key[best])
				best = i;
		r.key = head_key[best];
		r.pay = head_pay[best];
		r.flags.src = head_src[best];
		for (int unsigned i = best; i + 1 < n_heads; i++) begin
			head_key[i] = head_key[i+1];
			head_pay[i] = head_pay[i+1];
			head_src[i] = head_src[i+1];
		end
		n_heads--;
		awaited = r.flags.src;
	endfunction

	function automatic bit merge_request(input logic [kwm_pkg::SRC_BITS-1:0] s,
			input logic [15:0] k, input logic [31:0] p, input logic e, output merge_out_t r);
		logic [kwm_pkg::CNT_BITS-1:0] wanted;
		wanted = priming ? primed : kwm_pkg::CNT_BITS'(awaited);
		r = '0;
		if (kwm_pkg::CNT_BITS'(s) != wanted) begin
			r.flags.protocol_error = 1'b1;
			return 1'b1;
		end
		if (!e && n_heads < MAX_HEADS) begin
			head_key[n_heads] = k;
			head_pay[n_heads] = p;
			head_src[n_heads] = s;
			n_heads++;
		end
		if (priming) begin
			primed = primed + kwm_pkg::CNT_BITS'(1);
			awaited = primed[kwm_pkg::SRC_BITS-1:0];
			if (primed < group_width())
				return 1'b0;
			priming = 1'b0;
		end
		take_smallest(r);
		return 1'b1;
	endfunction

	task automatic compare_field(input string what, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %0h, got %0h", $realtime, what, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatches = 0;
			n_heads = 0;
			priming = 1'b1;
			primed = '0;
			awaited = '0;
			group_reg = kwm_pkg::CFG_RESET;
			emitted_q.delete();
			pending <= 0;
		end else begin
			if (cfg_wen)
				group_reg = cfg_wdata;
			// Results are taken before requests, so a result can never match a prediction
			// made at the same edge.
			if (res_valid && res_ready) begin
				got_r.key = out_key;
				got_r.pay = out_payload;
				got_r.flags.src = refill_source;
				got_r.flags.run_end = run_end;
				got_r.flags.protocol_error = protocol_error;
				if (emitted_q.size() == 0) begin
					$display("%0t: no result expected, got key %0h payload %0h source %0d",
						$realtime, out_key, out_payload, refill_source);
					mismatches++;
				end else begin
					want_r = emitted_q.pop_front();
					compare_field("out_key", 64'(want_r.key), 64'(got_r.key));
					compare_field("out_payload", 64'(want_r.pay), 64'(got_r.pay));
					compare_field("refill_source", 64'(want_r.flags.src),
						64'(got_r.flags.src));
					compare_field("run_end", 64'(want_r.flags.run_end),
						64'(got_r.flags.run_end));
					compare_field("protocol_error", 64'(want_r.flags.protocol_error),
						64'(got_r.flags.protocol_error));
				end
			end
			if (src_valid && src_ready)
				if (merge_request(source, sort_key, payload, end_marker, new_r))
					emitted_q.push_back(new_r);
			pending <= emitted_q.size();
		end
	end

endmodule

### bench/tb_top.sv
// Top of the k-way run merger bench: clock, reset, request and register stimulus, verdict.
// Depends on kwm_pkg, k_way_run_merger and kwm_checker.
`timescale 1ns / 1ps

module tb_top;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 30;
	localparam int PHASE_ITEMS   = 100;
	localparam int N_PHASES      = 8;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_wen = 1'b0;
	logic [kwm_pkg::CFG_BITS-1:0] cfg_wdata = '0;
	logic                         src_valid = 1'b0;
	logic                         src_ready;
	logic [kwm_pkg::SRC_BITS-1:0] source = '0;
	logic [15:0]                  sort_key = '0;
	logic [31:0]                  payload = '0;
	logic                         end_marker = 1'b0;
	logic                         res_valid;
	logic                         res_ready = 1'b0;
	logic [15:0]                  out_key;
	logic [31:0]                  out_payload;
	logic [kwm_pkg::SRC_BITS-1:0] refill_source;
	logic                         run_end;
	logic                         protocol_error;

	int mismatches;
	int pending;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Sender's view of the merge: which source the block wants next.
	bit                           priming = 1'b1;
	int                           primed = 0;
	logic [kwm_pkg::SRC_BITS-1:0] awaited = '0;
	logic [kwm_pkg::CFG_BITS-1:0] cur_cfg = kwm_pkg::CFG_RESET;

	k_way_run_merger u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.src_valid      (src_valid),
		.src_ready      (src_ready),
		.source         (source),
		.sort_key       (sort_key),
		.payload        (payload),
		.end_marker     (end_marker),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.out_key        (out_key),
		.out_payload    (out_payload),
		.refill_source  (refill_source),
		.run_end        (run_end),
		.protocol_error (protocol_error)
	);

	kwm_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.src_valid      (src_valid),
		.src_ready      (src_ready),
		.source         (source),
		.sort_key       (sort_key),
		.payload        (payload),
		.end_marker     (end_marker),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.out_key        (out_key),
		.out_payload    (out_payload),
		.refill_source  (refill_source),
		.run_end        (run_end),
		.protocol_error (protocol_error),
		.mismatches     (mismatches),
		.pending        (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int group_width(input logic [kwm_pkg::CFG_BITS-1:0] v);
		if (v == 0)
			return 1;
		if (v > 8)
			return 8;
		return int'(v);
	endfunction

	function automatic logic [15:0] pick_key();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3, 4: return 16'($urandom_range(7));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_payload();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_raw(input logic [kwm_pkg::SRC_BITS-1:0] s, input logic [15:0] k,
			input logic [31:0] p, input logic e);
		src_valid <= 1'b1;
		source <= s;
		sort_key <= k;
		payload <= p;
		end_marker <= e;
		do
			@(posedge clk);
		while (!src_ready);
	endtask

	// Waits for the emission or run end that the last request caused; error results pass by.
	task automatic wait_emission();
		src_valid <= 1'b0;
		do
			@(posedge clk);
		while (!(res_valid && res_ready && !protocol_error));
		if (run_end) begin
			priming = 1'b1;
			primed = 0;
		end else begin
			awaited = refill_source;
		end
	endtask

	task automatic send_good(input logic [15:0] k, input logic [31:0] p, input logic e);
		send_raw(priming ? kwm_pkg::SRC_BITS'(primed) : awaited, k, p, e);
		if (priming) begin
			primed++;
			if (primed >= group_width(cur_cfg)) begin
				priming = 1'b0;
				wait_emission();
			end
		end else begin
			wait_emission();
		end
	endtask

	task automatic send_noise(input logic [15:0] k, input logic [31:0] p, input logic e);
		int wanted;
		wanted = priming ? primed : int'(awaited);
		send_raw(kwm_pkg::SRC_BITS'((wanted + 1 + $urandom_range(6)) % 8), k, p, e);
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			src_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic hold_until_empty();
		src_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic drain();
		hold_until_empty();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_sources(input logic [kwm_pkg::CFG_BITS-1:0] v);
		drain();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		cur_cfg = v;
	endtask

	initial begin
		int gap;
		int sent;
		logic [kwm_pkg::CFG_BITS-1:0] cfg_pick;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, two sources from reset: wrong source while priming, a tie that
		// the earlier entry wins, wrong source on refill, an end marker with a live key.
		send_noise(16'h1234, 32'h0, 1'b0);
		send_good(16'hFFFF, 32'h0000_0000, 1'b0);
		send_good(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
		send_noise(16'h0, 32'hFFFF_FFFF, 1'b1);
		send_good(16'h0000, 32'hFFFF_FFFF, 1'b0);
		send_good(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		send_good(16'h0000, 32'h0000_0000, 1'b1);

		// A single source, then a shrink of the group in the middle of priming.
		set_sources(4'd1);
		send_good(16'h1234, 32'hA5A5_5A5A, 1'b0);
		send_good(16'h0, 32'h0, 1'b1);
		set_sources(4'd8);
		send_good(16'hFFFF, 32'h1, 1'b0);
		send_good(16'h0000, 32'h2, 1'b0);
		send_good(16'h0007, 32'h3, 1'b1);
		send_good(16'h0007, 32'h4, 1'b0);
		send_good(16'h8000, 32'h5, 1'b0);
		set_sources(4'd2);
		send_good(16'h0003, 32'h6, 1'b0);

		for (int phase = 0; phase < N_PHASES; phase++) begin
			case (phase)
				0: cfg_pick = 4'd1;
				1: cfg_pick = 4'd8;
				2: cfg_pick = 4'd0;
				3: cfg_pick = 4'd15;
				4: cfg_pick = 4'd3;
				6: cfg_pick = 4'd5;
				default: cfg_pick = kwm_pkg::CFG_BITS'($urandom_range(15));
			endcase
			set_sources(cfg_pick);
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct <= 73; end
				default: begin send_idle_pct = 28; recv_stall_pct <= 28; end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				gap = 0;
				while ($urandom_range(99) < send_idle_pct)
					gap++;
				pause(gap);
				// Whenever half the phase's items are sent, the sender holds back until every result is out.
				if (sent == PHASE_ITEMS / 2)
					hold_until_empty();
				if ($urandom_range(99) < 10) begin
					send_noise(pick_key(), pick_payload(), 1'($urandom));
				end else begin
					send_good(pick_key(), pick_payload(), $urandom_range(99) < 22);
					sent++;
				end
			end
		end

		drain();
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
